/* rtl/mcp_charge_division_position_macros.svh */
// Assertion macros for the charge-division position block.
// Used by cpd_checker; needs clk and rst in the including scope.
`ifndef MCP_CHARGE_DIVISION_POSITION_MACROS_SVH
`define MCP_CHARGE_DIVISION_POSITION_MACROS_SVH

// Checked only outside reset.
`define CPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define CPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/cpd_pkg.sv */
// Shared types and constants for the charge-division position block.
// No dependencies; imported by every module of the block.
`default_nettype none

package cpd_pkg;

  localparam int AMP_BITS      = 12;
  localparam int FRAC_BITS_DEF = 15;
  localparam int POS_BITS      = 16;
  localparam int SUM_BITS      = AMP_BITS + 2;
  localparam int NUM_DET       = 2;
  localparam int NUM_LANES     = 2 * NUM_DET;

  typedef logic [AMP_BITS-1:0]        amp_t;
  typedef logic signed [POS_BITS-1:0] pos_t;

  localparam amp_t LOW_RESET  = 12'd700;
  localparam amp_t HIGH_RESET = 12'd3839;

  // Configuration register indexes
  localparam logic REG_LOW  = 1'b0;
  localparam logic REG_HIGH = 1'b1;

  typedef struct packed {
    amp_t first_a;
    amp_t first_b;
    amp_t first_c;
    amp_t first_d;
    amp_t second_a;
    amp_t second_b;
    amp_t second_c;
    amp_t second_d;
  } in_t;

  typedef struct packed {
    pos_t x_first;
    pos_t y_first;
    logic valid_first;
    pos_t x_second;
    pos_t y_second;
    logic valid_second;
  } out_t;

  // Per-beat divider state handed from cell to cell.
  // Lanes: 0 x_first, 1 y_first, 2 x_second, 3 y_second; lane l uses detector l>>1.
  typedef struct packed {
    logic [NUM_DET-1:0]                 dv;
    logic [NUM_LANES-1:0]               neg;
    logic [NUM_DET-1:0][SUM_BITS-1:0]   sum;
    logic [NUM_LANES-1:0][SUM_BITS-1:0] rem;
  } lane_t;

endpackage

`default_nettype wire

/* rtl/cpd_front.sv */
// Entry cell: window test, corner sums and numerator magnitudes.
// Depends on cpd_pkg.
`default_nettype none

module cpd_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire cpd_pkg::in_t  in_data,
  input  wire cpd_pkg::amp_t low_thr,
  input  wire cpd_pkg::amp_t high_thr,
  output logic               v_out,
  output cpd_pkg::lane_t     lane_out,
  input  wire logic          ready_dn
);
  import cpd_pkg::*;

  amp_t                amp [NUM_DET][4];
  logic [NUM_DET-1:0]  dv;
  lane_t               lane_next;
  logic [AMP_BITS:0]   p_sum [NUM_LANES];
  logic [AMP_BITS:0]   n_sum [NUM_LANES];
  logic [AMP_BITS:0]   mag   [NUM_LANES];
  logic                v;
  lane_t               lane;

  assign amp[0][0] = in_data.first_a;
  assign amp[0][1] = in_data.first_b;
  assign amp[0][2] = in_data.first_c;
  assign amp[0][3] = in_data.first_d;
  assign amp[1][0] = in_data.second_a;
  assign amp[1][1] = in_data.second_b;
  assign amp[1][2] = in_data.second_c;
  assign amp[1][3] = in_data.second_d;

  function automatic logic in_win(amp_t val, amp_t lo, amp_t hi);
    return (val > lo) && (val < hi);
  endfunction

  // Window test and sums per detector
  always_comb begin
    lane_next = '0;
    for (int k = 0; k < NUM_DET; k++) begin
      dv[k] = in_win(amp[k][0], low_thr, high_thr) && in_win(amp[k][1], low_thr, high_thr) &&
              in_win(amp[k][2], low_thr, high_thr) && in_win(amp[k][3], low_thr, high_thr);
      lane_next.dv[k]  = dv[k];
      lane_next.sum[k] = SUM_BITS'(amp[k][0]) + SUM_BITS'(amp[k][1]) +
                         SUM_BITS'(amp[k][2]) + SUM_BITS'(amp[k][3]);
      // x: (a+d) - (b+c)
      p_sum[2*k]   = (AMP_BITS+1)'(amp[k][0]) + (AMP_BITS+1)'(amp[k][3]);
      n_sum[2*k]   = (AMP_BITS+1)'(amp[k][1]) + (AMP_BITS+1)'(amp[k][2]);
      // y: (b+d) - (a+c)
      p_sum[2*k+1] = (AMP_BITS+1)'(amp[k][1]) + (AMP_BITS+1)'(amp[k][3]);
      n_sum[2*k+1] = (AMP_BITS+1)'(amp[k][0]) + (AMP_BITS+1)'(amp[k][2]);
    end
    for (int l = 0; l < NUM_LANES; l++) begin
      lane_next.neg[l] = n_sum[l] > p_sum[l];
      mag[l]           = lane_next.neg[l] ? (n_sum[l] - p_sum[l]) : (p_sum[l] - n_sum[l]);
      lane_next.rem[l] = SUM_BITS'(mag[l]);
    end
  end

  assign in_ready = !v || ready_dn;

  // Beats with no valid detector are dropped here
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid && (|dv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      lane <= lane_next;
    end
  end

  assign v_out    = v;
  assign lane_out = lane;

endmodule

`default_nettype wire

/* rtl/cpd_div_cell.sv */
// One restoring-division cell: one quotient bit for each of the four lanes.
// Depends on cpd_pkg.
`default_nettype none

module cpd_div_cell #(
  parameter int FRAC_BITS = cpd_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                            clk,
  input  wire logic                                            rst,
  input  wire logic                                            v_in,
  input  wire cpd_pkg::lane_t                                  lane_in,
  input  wire logic [cpd_pkg::NUM_LANES-1:0][FRAC_BITS-1:0]    q_in,
  output logic                                                 ready_up,
  output logic                                                 v_out,
  output cpd_pkg::lane_t                                       lane_out,
  output logic [cpd_pkg::NUM_LANES-1:0][FRAC_BITS-1:0]         q_out,
  input  wire logic                                            ready_dn
);
  import cpd_pkg::*;

  logic [SUM_BITS:0]                    shifted [NUM_LANES];
  logic [SUM_BITS:0]                    diff    [NUM_LANES];
  logic [NUM_LANES-1:0]                 qbit;
  lane_t                                lane_next;
  logic [NUM_LANES-1:0][FRAC_BITS-1:0]  q_next;
  logic                                 v;
  lane_t                                lane;
  logic [NUM_LANES-1:0][FRAC_BITS-1:0]  q;

  // Shift remainder, trial subtract, keep or restore
  always_comb begin
    lane_next = lane_in;
    for (int l = 0; l < NUM_LANES; l++) begin
      shifted[l] = {lane_in.rem[l], 1'b0};
      diff[l]    = shifted[l] - {1'b0, lane_in.sum[l >> 1]};
      qbit[l]    = shifted[l] >= {1'b0, lane_in.sum[l >> 1]};
      lane_next.rem[l] = qbit[l] ? diff[l][SUM_BITS-1:0] : shifted[l][SUM_BITS-1:0];
      q_next[l]  = {q_in[l][FRAC_BITS-2:0], qbit[l]};
    end
  end

  assign ready_up = !v || ready_dn;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (ready_up) begin
      v <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && v_in) begin
      lane <= lane_next;
      q    <= q_next;
    end
  end

  assign v_out    = v;
  assign lane_out = lane;
  assign q_out    = q;

endmodule

`default_nettype wire

/* rtl/cpd_back.sv */
// Exit cell: applies sign, zeroes invalid detectors, holds the result beat.
// Depends on cpd_pkg.
`default_nettype none

module cpd_back #(
  parameter int FRAC_BITS = cpd_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire logic                                          v_in,
  input  wire cpd_pkg::lane_t                                lane_in,
  input  wire logic [cpd_pkg::NUM_LANES-1:0][FRAC_BITS-1:0]  q_in,
  output logic                                               ready_up,
  output logic                                               out_valid,
  input  wire logic                                          out_ready,
  output cpd_pkg::out_t                                      out_data
);
  import cpd_pkg::*;

  logic [FRAC_BITS:0]   sq  [NUM_LANES];
  pos_t                 pos [NUM_LANES];
  out_t                 res_next;
  logic                 ov;
  out_t                 res;

  // Signed quotient, fitted to the output width
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    assign sq[l] = lane_in.neg[l] ? ((FRAC_BITS+1)'(0) - {1'b0, q_in[l]}) : {1'b0, q_in[l]};
    if (FRAC_BITS + 1 >= POS_BITS) begin : g_trunc
      assign pos[l] = sq[l][POS_BITS-1:0];
    end else begin : g_sext
      assign pos[l] = {{(POS_BITS-FRAC_BITS-1){sq[l][FRAC_BITS]}}, sq[l]};
    end
  end

  always_comb begin
    res_next.valid_first  = lane_in.dv[0];
    res_next.valid_second = lane_in.dv[1];
    res_next.x_first      = lane_in.dv[0] ? pos[0] : '0;
    res_next.y_first      = lane_in.dv[0] ? pos[1] : '0;
    res_next.x_second     = lane_in.dv[1] ? pos[2] : '0;
    res_next.y_second     = lane_in.dv[1] ? pos[3] : '0;
  end

  assign ready_up = !ov || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (ready_up) begin
      ov <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && v_in) begin
      res <= res_next;
    end
  end

  assign out_valid = ov;
  assign out_data  = res;

endmodule

`default_nettype wire

/* rtl/mcp_charge_division_position.sv */
// Top level of the four-corner charge-division position block.
// Depends on cpd_pkg, cpd_front, cpd_div_cell and cpd_back.
//
//   channel  signals                      direction  beat
//   in       in_valid/in_ready/in_data    input      eight corner amplitudes
//   out      out_valid/out_ready/out_data output     x, y, valid per detector
//   cfg      cfg_we/cfg_index/cfg_data    input      threshold write
//
// One beat per cycle while the out channel does not stall; the path runs through the entry
// cell, one divider cell per quotient bit (restoring division, all four lanes at once),
// and the output register.
// rst is synchronous and clears all cell valid flags; thresholds go to 700/3839.
// A stalled out channel holds cells from the back; empty cells still accept,
// so bubbles close up before in_ready drops.
// Events with neither detector in window leave no result beat.
`default_nettype none

module mcp_charge_division_position #(
  parameter int FRAC_BITS = cpd_pkg::FRAC_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire cpd_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output cpd_pkg::out_t      out_data,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire cpd_pkg::amp_t cfg_data
);
  import cpd_pkg::*;

  amp_t                                 low_thr;
  amp_t                                 high_thr;
  logic [FRAC_BITS:0]                   v_s;
  lane_t                                lane_s [FRAC_BITS+1];
  logic [NUM_LANES-1:0][FRAC_BITS-1:0]  q_s    [FRAC_BITS+1];
  logic [FRAC_BITS:0]                   rdy;

  // Threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      low_thr  <= LOW_RESET;
      high_thr <= HIGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOW:  low_thr  <= cfg_data;
        REG_HIGH: high_thr <= cfg_data;
      endcase
    end
  end

  cpd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .low_thr  (low_thr),
    .high_thr (high_thr),
    .v_out    (v_s[0]),
    .lane_out (lane_s[0]),
    .ready_dn (rdy[0])
  );

  assign q_s[0] = '0;

  // Divider chain, one quotient bit per cell
  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_cell
    cpd_div_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .v_in     (v_s[k]),
      .lane_in  (lane_s[k]),
      .q_in     (q_s[k]),
      .ready_up (rdy[k]),
      .v_out    (v_s[k+1]),
      .lane_out (lane_s[k+1]),
      .q_out    (q_s[k+1]),
      .ready_dn (rdy[k+1])
    );
  end

  cpd_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .v_in      (v_s[FRAC_BITS]),
    .lane_in   (lane_s[FRAC_BITS]),
    .q_in      (q_s[FRAC_BITS]),
    .ready_up  (rdy[FRAC_BITS]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* rtl/cpd_checker.sv */
// Port-level checks for the charge-division position block, bound to the top.
// Depends on cpd_pkg and mcp_charge_division_position_macros.svh.
`default_nettype none
`include "mcp_charge_division_position_macros.svh"

module cpd_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire cpd_pkg::out_t out_data
);
  import cpd_pkg::*;

  // Reset empties the output register
  `CPD_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "result beat shown after reset")

  // A held beat stays put
  `CPD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result beat changed")

  // Every result has at least one detector in window
  `CPD_ASSERT(a_any_valid, out_valid |-> out_data.valid_first || out_data.valid_second, "result beat with no valid detector")

  // Out-of-window detectors read zero
  `CPD_ASSERT(a_first_zero, out_valid && !out_data.valid_first |-> out_data.x_first == 0 && out_data.y_first == 0, "invalid first detector not zero")
  `CPD_ASSERT(a_second_zero, out_valid && !out_data.valid_second |-> out_data.x_second == 0 && out_data.y_second == 0, "invalid second detector not zero")

endmodule

bind mcp_charge_division_position cpd_checker u_cpd_checker (.*);

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for mcp_charge_division_position.
// Depends on cpd_pkg and the RTL; it predicts each event's positions and
// checks every out beat against them.
module tb;
  import cpd_pkg::*;

  localparam int FRAC   = FRAC_BITS_DEF;
  localparam int SETTLE = 3 * (FRAC_BITS_DEF + 2);
  localparam int LIMIT  = 500000;
  localparam int LONG_HOLD = 600;

  typedef logic [3:0][AMP_BITS-1:0] quad_t;

  typedef struct {
    in_t amps;
    int  gap;
  } event_slot_t;

  typedef enum int {EV_BOTH, EV_FIRST, EV_SECOND, EV_NONE, EV_NOISE} event_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_LOW;
  amp_t cfg_data = '0;

  // Threshold copies used by the predictor
  amp_t low_thr  = LOW_RESET;
  amp_t high_thr = HIGH_RESET;

  event_slot_t event_queue[$];
  out_t        position_queue[$];
  int          failures = 0;
  bit          no_idle = 1'b0;
  int          cycles = 0;

  mcp_charge_division_position dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic bit in_window(amp_t v);
    return v > low_thr && v < high_thr;
  endfunction

  // (pos - neg) * 2^FRAC / sum, truncated toward zero
  function automatic pos_t frac_ratio(int pos, int neg, int sum);
    int mag;
    int q;
    mag = (pos >= neg) ? pos - neg : neg - pos;
    q = (mag << FRAC) / sum;
    if (neg > pos) q = -q;
    return pos_t'(q);
  endfunction

  task automatic locate(input amp_t a, input amp_t b, input amp_t c, input amp_t d,
                        output pos_t x, output pos_t y, output logic ok);
    int s;
    ok = in_window(a) && in_window(b) && in_window(c) && in_window(d);
    x = '0;
    y = '0;
    if (ok) begin
      s = int'(a) + int'(b) + int'(c) + int'(d);
      x = frac_ratio(int'(a) + int'(d), int'(b) + int'(c), s);
      y = frac_ratio(int'(b) + int'(d), int'(a) + int'(c), s);
    end
  endtask

  task automatic predict_positions(input in_t e, output out_t r, output bit emits);
    locate(e.first_a, e.first_b, e.first_c, e.first_d,
           r.x_first, r.y_first, r.valid_first);
    locate(e.second_a, e.second_b, e.second_c, e.second_d,
           r.x_second, r.y_second, r.valid_second);
    emits = r.valid_first || r.valid_second;
  endtask

  // ---------------------------------------------------------------- stimulus helpers
  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(19, 0);
  endfunction

  function automatic amp_t inside_amp();
    if (int'(high_thr) <= int'(low_thr) + 1) return amp_t'($urandom);
    case ($urandom_range(7, 0))
      0: return low_thr + 1'b1;
      1: return high_thr - 1'b1;
      default: return amp_t'($urandom_range(int'(high_thr) - 1, int'(low_thr) + 1));
    endcase
  endfunction

  function automatic amp_t outside_amp();
    if ($urandom_range(1, 0)) return amp_t'($urandom_range(int'(low_thr), 0));
    return amp_t'($urandom_range(4095, int'(high_thr)));
  endfunction

  // Four corners, all in window, or broken by one or more corners outside
  function automatic quad_t make_quad(bit good);
    quad_t q;
    int k;
    for (k = 0; k < 4; k++) q[k] = inside_amp();
    if (!good) begin
      q[$urandom_range(3, 0)] = outside_amp();
      if ($urandom_range(3, 0) == 0) q[$urandom_range(3, 0)] = outside_amp();
    end
    return q;
  endfunction

  function automatic in_t make_event();
    event_kind_t kind;
    int roll;
    quad_t f;
    quad_t s;
    in_t e;
    roll = $urandom_range(99, 0);
    if (roll < 45) kind = EV_BOTH;
    else if (roll < 60) kind = EV_FIRST;
    else if (roll < 75) kind = EV_SECOND;
    else if (roll < 85) kind = EV_NONE;
    else kind = EV_NOISE;
    f = make_quad(kind == EV_BOTH || kind == EV_FIRST);
    s = make_quad(kind == EV_BOTH || kind == EV_SECOND);
    if (kind == EV_NOISE) begin
      f = quad_t'({$urandom, $urandom});
      s = quad_t'({$urandom, $urandom});
    end
    e.first_a  = f[0];
    e.first_b  = f[1];
    e.first_c  = f[2];
    e.first_d  = f[3];
    e.second_a = s[0];
    e.second_b = s[1];
    e.second_c = s[2];
    e.second_d = s[3];
    return e;
  endfunction

  task automatic push_event(input in_t e);
    event_slot_t slot;
    slot.amps = e;
    slot.gap  = draw_gap();
    event_queue.push_back(slot);
  endtask

  task automatic push_amps(input int fa, fb, fc, fd, sa, sb, sc, sd);
    push_event({amp_t'(fa), amp_t'(fb), amp_t'(fc), amp_t'(fd),
                amp_t'(sa), amp_t'(sb), amp_t'(sc), amp_t'(sd)});
  endtask

  // Wait until every event is in and every position is out, then let the
  // pipeline flush events that leave no beat
  task automatic drain();
    do @(negedge clk);
    while (event_queue.size() != 0 || in_valid || position_queue.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input amp_t val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_LOW) low_thr = val;
    else high_thr = val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_window(input amp_t lo, input amp_t hi);
    write_reg(REG_LOW, lo);
    write_reg(REG_HIGH, hi);
  endtask

  task automatic run_phase(input int n, input bit burst);
    no_idle = burst;
    repeat (n) push_event(make_event());
    drain();
  endtask

  // ---------------------------------------------------------------- driver
  int gap_left = 0;
  bit gap_armed = 1'b0;

  always @(posedge clk) begin : drive
    event_slot_t slot;
    out_t want;
    bit emits;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
      gap_armed = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_positions(in_data, want, emits);
        if (emits) position_queue.push_back(want);
      end
      // slot is free: take the next event after its gap
      if (!in_valid || in_ready) begin
        if (event_queue.size() != 0 && !gap_armed) begin
          gap_left = event_queue[0].gap;
          gap_armed = 1'b1;
        end
        if (event_queue.size() != 0 && gap_left == 0) begin
          slot = event_queue.pop_front();
          in_data  <= slot.amps;
          in_valid <= 1'b1;
          gap_armed = 1'b0;
        end else begin
          in_valid <= 1'b0;
          if (gap_left != 0) gap_left--;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic check_field(input string name, input logic signed [16:0] want,
                             input logic signed [16:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  int stall_left = 0;
  int beats = 0;

  always @(posedge clk) begin : watch
    out_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (position_queue.size() == 0) begin
          $error("out beat with no event waiting for it");
          failures++;
        end else begin
          want = position_queue.pop_front();
          check_field("x_first", want.x_first, out_data.x_first);
          check_field("y_first", want.y_first, out_data.y_first);
          check_field("valid_first", want.valid_first, out_data.valid_first);
          check_field("x_second", want.x_second, out_data.x_second);
          check_field("y_second", want.y_second, out_data.y_second);
          check_field("valid_second", want.valid_second, out_data.valid_second);
        end
        beats++;
        stall_left = no_idle ? 0 : $urandom_range(19, 0);
        // long hold-off so the pipeline fills and in_ready drops
        if (beats == 150 || beats == 700) stall_left = LONG_HOLD;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin : stimulus
    amp_t lo;
    amp_t hi;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed events at the reset window (700, 3839)
    push_amps(701, 701, 701, 701, 701, 701, 701, 701);               // centered, minimum
    push_amps(3838, 3838, 3838, 3838, 3838, 3838, 3838, 3838);       // centered, maximum
    push_amps(3838, 701, 701, 701, 701, 701, 701, 3838);             // one hot corner
    push_amps(701, 3838, 701, 701, 701, 701, 3838, 701);
    push_amps(3838, 701, 701, 3838, 701, 3838, 3838, 701);           // largest |x|
    push_amps(701, 3838, 701, 3838, 3838, 701, 3838, 701);           // largest |y|
    push_amps(1000, 2000, 3000, 1500, 0, 0, 0, 0);                   // second all zero
    push_amps(4095, 4095, 4095, 4095, 1200, 3300, 900, 2500);        // first full scale
    push_amps(700, 1000, 1000, 1000, 3839, 3839, 3839, 3839);        // on thresholds: none
    push_amps(0, 0, 0, 0, 0, 0, 0, 0);                               // neither valid
    push_amps(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);       // neither valid
    push_amps(1500, 1500, 1500, 3839, 2000, 2000, 2000, 701);        // first on high edge
    push_amps(2730, 1365, 2730, 1365, 1365, 2730, 1365, 2730);       // alternating bits
    push_amps(1234, 2345, 3456, 777, 1111, 2222, 3333, 4095);        // second one corner out
    push_amps(701, 3838, 3838, 701, 3838, 3838, 701, 701);
    run_phase(300, 1'b0);

    // Widest window, no idling
    set_window(12'd0, 12'd4095);
    run_phase(300, 1'b1);

    // Inverted window: nothing can be valid
    set_window(12'd4095, 12'd0);
    run_phase(40, 1'b0);

    // Equal thresholds: empty window
    set_window(12'd2000, 12'd2000);
    run_phase(40, 1'b0);

    // Narrow window, no idling
    set_window(12'd1000, 12'd1003);
    run_phase(150, 1'b1);

    // Only amplitude 1 counts
    set_window(12'd0, 12'd2);
    run_phase(60, 1'b0);

    // A few random windows
    repeat (5) begin
      lo = amp_t'($urandom_range(2000, 0));
      hi = amp_t'($urandom_range(4095, int'(lo) + 2));
      set_window(lo, hi);
      run_phase(50, $urandom_range(3, 0) == 0);
    end

    // Back to the reset window
    set_window(LOW_RESET, HIGH_RESET);
    run_phase(200, 1'b0);

    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
